[sv/ipd_pkg.sv]
// Shared types and constants for the inertial sensor packet deframer.
// No dependencies; used by ipd_ctrl, ipd_datapath and the core top level.
package ipd_pkg;

	localparam int unsigned NUM_WORDS = 19;
	localparam int unsigned IDX_W     = 5;
	localparam int unsigned POS_W     = 9;

	localparam logic [7:0] PRE_FIRST  = 8'hFA;
	localparam logic [7:0] PRE_SECOND = 8'hFF;

	localparam logic [POS_W-1:0] LEN_MIN   = 9'd98;
	localparam logic [POS_W-1:0] LEN_MAX   = 9'd259;
	localparam logic [POS_W-1:0] LEN_RESET = 9'd99;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);

	// first packet byte of each big-endian float word
	localparam logic [POS_W-1:0] WORD_START [NUM_WORDS] = '{
		9'd7,  9'd11, 9'd15, 9'd22, 9'd26, 9'd30, 9'd37, 9'd41, 9'd45, 9'd52,
		9'd56, 9'd60, 9'd67, 9'd71, 9'd75, 9'd79, 9'd86, 9'd90, 9'd94
	};

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} word_hit_t;

	// controller -> datapath
	typedef struct packed {
		logic busy;       // input side stalled
		logic start_pkt;  // second preamble byte accepted
		logic pkt_byte;   // packet byte accepted
		logic emit_load;  // load next word into output register
	} ipd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic byte_fa;
		logic byte_ff;
		logic pkt_end;
		logic out_free;
		logic emit_last;
	} ipd_status_t;

	// word whose final byte sits at this packet position, if any
	function automatic word_hit_t word_end_lookup(input logic [POS_W-1:0] pos);
		word_hit_t r;
		r.hit = 1'b0;
		r.idx = '0;
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (pos == WORD_START[k] + 9'd3) begin
				r.hit = 1'b1;
				r.idx = IDX_W'(k);
			end
		end
		return r;
	endfunction

endpackage

[sv/ipd_ctrl.sv]
// Controller state machine: preamble hunt, packet count and word burst.
// Depends on ipd_pkg for the command and status structs.
module ipd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  ipd_pkg::ipd_status_t status,
	output ipd_pkg::ipd_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_SEEN_FA,
		ST_PACKET,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   in_fire;

	assign cmd.busy      = (state_q == ST_EMIT);
	assign in_fire       = in_valid && !cmd.busy;
	assign cmd.start_pkt = (state_q == ST_SEEN_FA) && in_fire && status.byte_ff;
	assign cmd.pkt_byte  = (state_q == ST_PACKET) && in_fire;
	assign cmd.emit_load = (state_q == ST_EMIT) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			case (state_q)
				ST_HUNT: begin
					if (in_fire && status.byte_fa)
						state_q <= ST_SEEN_FA;
				end
				ST_SEEN_FA: begin
					if (in_fire) begin
						if (status.byte_ff)
							state_q <= ST_PACKET;
						else if (!status.byte_fa)
							state_q <= ST_HUNT;
					end
				end
				ST_PACKET: begin
					if (in_fire && status.pkt_end)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (status.out_free && status.emit_last)
						state_q <= ST_HUNT;
				end
				default: state_q <= ST_HUNT;
			endcase
		end
	end

endmodule

[sv/ipd_datapath.sv]
// Datapath: length register, position counter, byte sum, word assembly,
// word store and output register. Depends on ipd_pkg.
module ipd_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ipd_pkg::POS_W-1:0]          msg_length,
	input  logic [7:0]                         rx_byte,
	input  logic                               out_stall,
	input  ipd_pkg::ipd_cmd_t                  cmd,
	output ipd_pkg::ipd_status_t               status,
	output logic                               out_valid,
	output logic [ipd_pkg::IDX_W-1:0]          word_index,
	output logic [31:0]                        word_value,
	output logic                               checksum_ok,
	output logic                               last
);

	logic [ipd_pkg::POS_W-1:0] len_q;
	logic [ipd_pkg::POS_W-1:0] len_eff;
	logic [ipd_pkg::POS_W-1:0] pos_q;
	logic [7:0]                sum_q;
	logic [7:0]                sum_next;
	logic [23:0]               sh_q;
	logic                      ok_q;
	logic [ipd_pkg::IDX_W-1:0] rd_idx_q;
	logic                      out_valid_q;
	logic [ipd_pkg::IDX_W-1:0] word_index_q;
	logic [31:0]               word_value_q;
	logic                      checksum_ok_q;
	logic                      last_q;
	ipd_pkg::word_hit_t        hit;
	logic [31:0]               store_q [ipd_pkg::NUM_WORDS];

	always_comb begin
		len_eff = len_q;
		if (len_q < ipd_pkg::LEN_MIN)
			len_eff = ipd_pkg::LEN_MIN;
		else if (len_q > ipd_pkg::LEN_MAX)
			len_eff = ipd_pkg::LEN_MAX;
	end

	assign sum_next = sum_q + rx_byte;
	assign hit      = ipd_pkg::word_end_lookup(pos_q);

	assign status.byte_fa   = (rx_byte == ipd_pkg::PRE_FIRST);
	assign status.byte_ff   = (rx_byte == ipd_pkg::PRE_SECOND);
	assign status.pkt_end   = ({1'b0, pos_q} + 10'd1) >= {1'b0, len_eff};
	assign status.out_free  = !out_valid_q || !out_stall;
	assign status.emit_last = (rd_idx_q == ipd_pkg::LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= ipd_pkg::LEN_RESET;
			pos_q       <= '0;
			sum_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				len_q <= msg_length;
			if (cmd.start_pkt) begin
				pos_q <= 9'd2;
				sum_q <= ipd_pkg::PRE_SECOND;
			end else if (cmd.pkt_byte) begin
				if (status.pkt_end) begin
					pos_q    <= '0;
					sum_q    <= '0;
					rd_idx_q <= '0;
				end else begin
					pos_q <= pos_q + 9'd1;
					sum_q <= sum_next;
				end
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
				rd_idx_q    <= status.emit_last ? '0 : rd_idx_q + 5'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers and the word store
	always_ff @(posedge clk) begin
		if (cmd.pkt_byte) begin
			sh_q <= {sh_q[15:0], rx_byte};
			if (hit.hit)
				store_q[hit.idx] <= {sh_q, rx_byte};
			if (status.pkt_end)
				ok_q <= (sum_next == 8'd0);
		end
		if (cmd.emit_load) begin
			word_value_q  <= store_q[rd_idx_q];
			word_index_q  <= rd_idx_q;
			checksum_ok_q <= ok_q;
			last_q        <= status.emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign word_index  = word_index_q;
	assign word_value  = word_value_q;
	assign checksum_ok = checksum_ok_q;
	assign last        = last_q;

endmodule

[sv/imu_packet_deframer_core.sv]
// Inertial sensor packet deframer: hunts for the 0xFA 0xFF preamble, counts a
// packet of msg_length bytes (held to 98..259), checks the 8-bit byte sum and
// emits nineteen big-endian float words. Depends on ipd_pkg, ipd_ctrl, ipd_datapath.
//
// rx_byte is never stalled while hunting or inside a packet. After a packet's
// last byte the input stalls while the nineteen words go out, one per cycle
// when out_stall is low; the burst is paced by the single read port of the
// word store and the one-deep output register.
module imu_packet_deframer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ipd_pkg::POS_W-1:0] msg_length,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ipd_pkg::IDX_W-1:0] word_index,
	output logic [31:0]               word_value,
	output logic                      checksum_ok,
	output logic                      last
);

	ipd_pkg::ipd_cmd_t    cmd;
	ipd_pkg::ipd_status_t status;

	assign cfg_ready = 1'b1;
	assign in_stall  = cmd.busy;

	ipd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.status  (status),
		.cmd     (cmd)
	);

	ipd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.msg_length (msg_length),
		.rx_byte    (rx_byte),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.word_index (word_index),
		.word_value (word_value),
		.checksum_ok(checksum_ok),
		.last       (last)
	);

	// last flag marks the final word only
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (word_index == ipd_pkg::LAST_IDX)))
		else $error("last flag and word index disagree");

	// burst runs without gaps once a non-final word is taken
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside word burst");

	a_burst_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> word_index == $past(word_index) + 5'd1)
		else $error("word burst out of order");

endmodule

[verif/testbench.sv]
// Self-checking testbench for imu_packet_deframer_core: byte stream in, float words out.
// Depends on ipd_pkg and the deframer RTL; prediction is done by an in-bench deframer.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {HUNT_FA, AWAIT_FF, IN_PACKET} deframe_phase_t;
	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_PREAMBLE} fill_t;

	typedef struct {
		logic [ipd_pkg::IDX_W-1:0] idx;
		logic [31:0]               value;
		logic                      ok;
		logic                      last;
	} word_result_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      cfg_valid  = 1'b0;
	logic                      cfg_ready;
	logic [ipd_pkg::POS_W-1:0] msg_length = ipd_pkg::LEN_RESET;
	logic                      in_valid   = 1'b0;
	logic                      in_stall;
	logic [7:0]                rx_byte    = 8'h00;
	logic                      out_valid;
	logic                      out_stall  = 1'b0;
	logic [ipd_pkg::IDX_W-1:0] word_index;
	logic [31:0]               word_value;
	logic                      checksum_ok;
	logic                      last;

	imu_packet_deframer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.msg_length (msg_length),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.word_index (word_index),
		.word_value (word_value),
		.checksum_ok(checksum_ok),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// deframer state as predicted from accepted bytes
	deframe_phase_t            phase_q = HUNT_FA;
	logic [ipd_pkg::POS_W-1:0] pos_q   = '0;
	logic [7:0]                sum_q   = 8'h00;
	logic [31:0]               word_q [ipd_pkg::NUM_WORDS];
	logic [ipd_pkg::POS_W-1:0] len_reg = ipd_pkg::LEN_RESET;
	word_result_t              pending_words [$];

	int   errors   = 0;
	bit   calm     = 1'b0;
	bit   hold_req = 1'b0;
	logic out_hold = 1'b0;

	function automatic int unsigned clamped_length();
		if (len_reg < ipd_pkg::LEN_MIN)
			return ipd_pkg::LEN_MIN;
		if (len_reg > ipd_pkg::LEN_MAX)
			return ipd_pkg::LEN_MAX;
		return len_reg;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		word_result_t r;
		case (phase_q)
			AWAIT_FF: begin
				if (b == ipd_pkg::PRE_SECOND) begin
					phase_q = IN_PACKET;
					pos_q   = 9'd2;
					sum_q   = ipd_pkg::PRE_SECOND;
				end else if (b != ipd_pkg::PRE_FIRST) begin
					phase_q = HUNT_FA;
				end
			end
			IN_PACKET: begin
				sum_q = sum_q + b;
				for (int k = 0; k < ipd_pkg::NUM_WORDS; k++)
					if (pos_q >= ipd_pkg::WORD_START[k] && pos_q - ipd_pkg::WORD_START[k] < 4)
						word_q[k] = {word_q[k][23:0], b};
				if (int'(pos_q) + 1 >= clamped_length()) begin
					for (int k = 0; k < ipd_pkg::NUM_WORDS; k++) begin
						r.idx   = ipd_pkg::IDX_W'(k);
						r.value = word_q[k];
						r.ok    = (sum_q == 8'h00);
						r.last  = (k == ipd_pkg::NUM_WORDS - 1);
						pending_words.push_back(r);
					end
					phase_q = HUNT_FA;
					pos_q   = '0;
					sum_q   = 8'h00;
				end else begin
					pos_q = pos_q + 1'b1;
				end
			end
			default: phase_q = (b == ipd_pkg::PRE_FIRST) ? AWAIT_FF : HUNT_FA;
		endcase
	endtask

	// one byte request; valid stays high afterwards unless the next call idles
	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		deframe_byte(b);
	endtask

	function automatic logic [7:0] data_byte(input fill_t mode);
		case (mode)
			FILL_ZERO:     return 8'h00;
			FILL_ONES:     return 8'hFF;
			FILL_PREAMBLE: begin
				case ($urandom_range(3))
					0:       return ipd_pkg::PRE_FIRST;
					1:       return ipd_pkg::PRE_SECOND;
					default: return 8'($urandom_range(255));
				endcase
			end
			default:       return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_packet(input int unsigned n, input bit good, input fill_t mode);
		logic [7:0] s;
		logic [7:0] b;
		send_byte(ipd_pkg::PRE_FIRST);
		send_byte(ipd_pkg::PRE_SECOND);
		s = ipd_pkg::PRE_SECOND;
		for (int unsigned i = 2; i < n - 1; i++) begin
			b = data_byte(mode);
			s = s + b;
			send_byte(b);
		end
		b = 8'h00 - s;
		if (!good)
			b = b + 8'($urandom_range(1, 255));
		send_byte(b);
	endtask

	task automatic send_noise(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0:       b = ipd_pkg::PRE_FIRST;
				1:       b = ipd_pkg::PRE_SECOND;
				default: b = 8'($urandom_range(255));
			endcase
			// keep noise from opening a packet by accident
			if (phase_q == AWAIT_FF && b == ipd_pkg::PRE_SECOND)
				b = ipd_pkg::PRE_FIRST;
			send_byte(b);
		end
	endtask

	// finish any open packet, then wait out the word burst
	task automatic drain_to_idle();
		while (phase_q != HUNT_FA)
			send_byte(8'h00);
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_length(input logic [ipd_pkg::POS_W-1:0] v);
		drain_to_idle();
		cfg_valid  <= 1'b1;
		msg_length <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		len_reg = v;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < 40)
			$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		word_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word_index", 32'(word_index), 32'h0);
			end else begin
				w = pending_words.pop_front();
				if (word_index != w.idx)
					report_mismatch("word_index", 32'(word_index), 32'(w.idx));
				if (word_value != w.value)
					report_mismatch("word_value", word_value, w.value);
				if (checksum_ok != w.ok)
					report_mismatch("checksum_ok", 32'(checksum_ok), 32'(w.ok));
				if (last != w.last)
					report_mismatch("last", 32'(last), 32'(w.last));
			end
		end
	end

	always @(posedge clk)
		out_stall <= out_hold || (!calm && $urandom_range(99) < 23);

	// long output hold-off so the core backs up into its input
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_hold <= 1'b1;
				repeat (400) @(posedge clk);
				out_hold <= 1'b0;
			end
		end
	end

	task automatic test_reset_length();
		send_packet(clamped_length(), 1'b1, FILL_RANDOM);
		drain_to_idle();
	endtask

	task automatic test_preamble_hunt();
		// stray second byte, broken preamble, then repeated first bytes
		send_byte(ipd_pkg::PRE_SECOND);
		send_byte(ipd_pkg::PRE_FIRST);
		send_byte(8'h00);
		send_byte(ipd_pkg::PRE_SECOND);
		send_byte(ipd_pkg::PRE_FIRST);
		send_byte(ipd_pkg::PRE_FIRST);
		send_byte(ipd_pkg::PRE_FIRST);
		send_noise(6);
		// preamble bytes inside the packet are plain data
		send_packet(clamped_length(), 1'b0, FILL_PREAMBLE);
		drain_to_idle();
	endtask

	task automatic test_length_extremes();
		// lengths above the range saturate to the longest packet
		write_length(9'h1FF);
		send_packet(clamped_length(), 1'b1, FILL_PREAMBLE);
		drain_to_idle();
	endtask

	task automatic test_output_holdoff();
		// zero length saturates to the shortest packet
		write_length(9'd0);
		calm = 1'b1;
		hold_req = 1'b1;
		send_packet(clamped_length(), 1'b1, FILL_RANDOM);
		// keep offering bytes while the burst is held off
		send_noise(8);
		drain_to_idle();
		calm = 1'b0;
	endtask

	initial begin
		for (int k = 0; k < ipd_pkg::NUM_WORDS; k++)
			word_q[k] = 32'h0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_length();
		test_preamble_hunt();
		test_length_extremes();
		test_output_holdoff();
		if (errors == 0)
			$display("[imu_packet_deframer_core] OK");
		else
			$display("[imu_packet_deframer_core] ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("[imu_packet_deframer_core] ERROR");
		$finish;
	end

endmodule
